// ===== rtl/core/upq_pkg.sv =====
// Shared types and codes for the unordered min/max priority queue.
// No dependencies.
package upq_pkg;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXTRACTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;

    typedef struct packed {
        logic valid;
        logic first;
        logic want_max;
    } scan_ctl_t;

endpackage

// ===== rtl/core/upq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read.
// No dependencies.
module upq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/upq_scan.sv =====
// Running minimum/maximum tracker fed by the read stream of the entry store.
// Depends on upq_pkg.
module upq_scan
    import upq_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic               aclk,
    input  scan_ctl_t          ctl,
    input  logic [VALUE_W-1:0] rd_data,
    input  logic [IDX_W-1:0]   rd_idx,
    output logic [VALUE_W-1:0] best_val,
    output logic [IDX_W-1:0]   best_idx,
    output logic [VALUE_W-1:0] last_val
);

    logic [VALUE_W-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [VALUE_W-1:0] last_val_reg, last_val_next;
    logic               better;

    // strict compare: scanning downward, ties keep the higher index
    assign better = ctl.want_max ? ($signed(best_val_reg) < $signed(rd_data))
                                 : ($signed(rd_data) < $signed(best_val_reg));

    always_comb begin
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        last_val_next = last_val_reg;
        if (ctl.valid) begin
            if (ctl.first) begin
                best_val_next = rd_data;
                best_idx_next = rd_idx;
                last_val_next = rd_data;
            end else if (better) begin
                best_val_next = rd_data;
                best_idx_next = rd_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        last_val_reg <= last_val_next;
    end

    assign best_val = best_val_reg;
    assign best_idx = best_idx_reg;
    assign last_val = last_val_reg;

endmodule

// ===== rtl/core/unordered_min_max_priority_queue.sv =====
// Unordered min/max priority queue: sequencer, entry store and scan unit.
// Depends on upq_pkg, upq_ram and upq_scan.
// Insert or empty extract: S_DONE follows acceptance and registers the result word.
// Extract: S_SCAN makes one store read per entry, then S_WAIT, S_WRITE and S_DONE;
// either way the next word is accepted once S_DONE has registered the result word.
// Reset (aresetn low, synchronous) empties the queue; store contents are kept.
module unordered_min_max_priority_queue
    import upq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // func[1:0], value[33:2], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status[1:0], result_value[33:2],
                                           // occupancy[38:34], queue_empty[39]
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       wp_reg, wp_next;
    logic [IW-1:0]       addr_reg, addr_next;
    logic                want_max_reg, want_max_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                rd_first_reg, rd_first_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [FUNC_W-1:0]   in_func;
    logic [VALUE_W-1:0]  in_value;
    logic [CW-1:0]       cnt_m1;
    logic [CW+OCC_W-1:0] occ_wide;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic [VALUE_W-1:0]  ram_rdata;

    scan_ctl_t           scan_ctl;
    logic [VALUE_W-1:0]  best_val;
    logic [IW-1:0]       best_idx;
    logic [VALUE_W-1:0]  last_val;

    assign in_func  = s_tdata[1:0];
    assign in_value = s_tdata[33:2];
    assign cnt_m1   = count_reg - 1'b1;
    assign occ_wide = {{OCC_W{1'b0}}, count_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign scan_ctl.valid    = rd_valid_reg;
    assign scan_ctl.first    = rd_first_reg;
    assign scan_ctl.want_max = want_max_reg;

    upq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    upq_scan #(
        .IDX_W (IW)
    ) u_scan (
        .aclk     (aclk),
        .ctl      (scan_ctl),
        .rd_data  (ram_rdata),
        .rd_idx   (rd_idx_reg),
        .best_val (best_val),
        .best_idx (best_idx),
        .last_val (last_val)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        wp_next         = wp_reg;
        addr_next       = addr_reg;
        want_max_next   = want_max_reg;
        rd_valid_next   = 1'b0;
        rd_first_next   = rd_first_reg;
        rd_idx_next     = rd_idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = wp_reg;
        ram_wdata       = in_value;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (rd_valid_reg) begin
            rd_first_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (in_func == FN_INSERT) begin
                        ram_we          = 1'b1;
                        wp_next         = (wp_reg == IW'(CAPACITY - 1)) ? '0 : wp_reg + 1'b1;
                        if (count_reg != CW'(CAPACITY)) begin
                            count_next = count_reg + 1'b1;
                        end
                        res_status_next = ST_INSERTED;
                        res_value_next  = '0;
                        state_next      = S_DONE;
                    end else if (count_reg == '0) begin
                        res_status_next = ST_EMPTY;
                        res_value_next  = '0;
                        state_next      = S_DONE;
                    end else begin
                        want_max_next = in_func[1];
                        addr_next     = cnt_m1[IW-1:0];
                        rd_first_next = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_valid_next = 1'b1;
                rd_idx_next   = addr_reg;
                if (addr_reg == '0) begin
                    state_next = S_WAIT;
                end else begin
                    addr_next = addr_reg - 1'b1;
                end
            end
            S_WAIT: begin
                state_next = S_WRITE;
            end
            S_WRITE: begin
                // move the last occupied entry into the extracted slot
                ram_we          = 1'b1;
                ram_waddr       = best_idx;
                ram_wdata       = last_val;
                res_status_next = ST_EXTRACTED;
                res_value_next  = best_val;
                count_next      = cnt_m1;
                wp_next         = cnt_m1[IW-1:0];
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(count_reg == '0), occ_wide[OCC_W-1:0],
                                    res_value_reg, res_status_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            wp_reg       <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            wp_reg       <= wp_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        addr_reg       <= addr_next;
        want_max_reg   <= want_max_next;
        rd_first_reg   <= rd_first_next;
        rd_idx_reg     <= rd_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_data_reg     <= m_data_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_wp_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CW'(CAPACITY)) |-> (CW'(wp_reg) == count_reg))
        else $error("write position out of step with entry count");

    a_insert_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_func == FN_INSERT) |=> (count_reg != '0))
        else $error("queue empty after insert");

    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == ST_EMPTY) |-> (m_tdata[33:2] == '0 && m_tdata[39]))
        else $error("empty-queue word carries data or nonempty flag");

    a_scan_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_WAIT) |-> !ram_we)
        else $error("store written during scan");
`endif

endmodule
